FILE: src/causal_conv_step_silu_macros.svh
// ----------------------------------------------------------------------------
// causal_conv_step_silu assertion macros
// Shared concurrent assertion forms, reset-qualified on the active-low reset.
// ----------------------------------------------------------------------------
`ifndef CAUSAL_CONV_STEP_SILU_MACROS_SVH
`define CAUSAL_CONV_STEP_SILU_MACROS_SVH

// same-cycle implication
`define CCSS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ccss assertion failed");

// next-cycle implication
`define CCSS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ccss assertion failed");

`endif

FILE: src/ccss_pkg.sv
// ----------------------------------------------------------------------------
// ccss_pkg
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ccss_pkg;

    localparam int NUM_TAPS    = 4;
    localparam int CHANNELS    = 1024;
    localparam int BATCH_SLOTS = 4;
    localparam int HIST_LEN    = NUM_TAPS - 1;

    localparam int CH_W   = 10;
    localparam int SLOT_W = 2;
    localparam int TAP_W  = 2;
    localparam int ROW_W  = SLOT_W + CH_W;
    localparam int KCNT_W = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam int ROWS   = BATCH_SLOTS * CHANNELS;
    localparam int CLR_W  = $clog2(ROWS);

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_HIST   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_MAC,
        ST_ROUND,
        ST_MULT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr;      // clearing pass step
        logic capture;  // latch input word
        logic rd;       // start of sample, memory read cycle
        logic mac;      // one tap of the dot product
        logic rnd;      // round sum, form sigmoid
        logic mul;      // x * sigmoid
        logic fin;      // shift history, load output
        logic wr;       // store a write word
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic tap_last;
        logic out_full;
    } sts_t;

endpackage

FILE: src/ccss_ctrl.sv
// ----------------------------------------------------------------------------
// ccss_ctrl
// Sequencer: clearing pass, then one item at a time through the datapath.
// ----------------------------------------------------------------------------
`include "causal_conv_step_silu_macros.svh"

module ccss_ctrl
    import ccss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  op_t  in_op,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == OP_SAMPLE) ? ST_READ : ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.wr     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac = 1'b1;
                if (sts.tap_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.rnd    = 1'b1;
                state_next = ST_MULT;
            end
            ST_MULT: begin
                cmd.mul    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!sts.out_full) begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `CCSS_ASSERT_IMP(a_fin_no_overwrite, aclk, aresetn, cmd.fin, !sts.out_full)
    `CCSS_ASSERT_NXT(a_capture_then_work, aclk, aresetn, cmd.capture, cmd.rd || cmd.wr)
    `CCSS_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn, cmd.clr, !in_ready)

endmodule

FILE: src/ccss_dp.sv
// ----------------------------------------------------------------------------
// ccss_dp
// Stores, tap-serial multiply-accumulate, SiLU and the output register.
// ----------------------------------------------------------------------------
module ccss_dp
    import ccss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic                cfg_we,
    input  logic                cfg_bit,
    input  logic [1:0]          in_op,
    input  logic [SLOT_W-1:0]   in_slot,
    input  logic [CH_W-1:0]     in_ch,
    input  logic [TAP_W-1:0]    in_tap,
    input  logic signed [15:0]  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  out_act,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [CH_W-1:0]     out_ch
);

    function automatic logic [12:0] sigmoid_q12(input logic signed [23:0] x);
        logic [23:0] a;
        logic [12:0] g;
        a = x[23] ? 24'(-x) : 24'(x);
        if (a >= 24'd20480) begin
            g = 13'd4096;
        end else if (a >= 24'd9728) begin
            g = 13'(a >> 5) + 13'd3456;
        end else if (a >= 24'd4096) begin
            g = 13'(a >> 3) + 13'd2560;
        end else begin
            g = 13'(a >> 2) + 13'd2048;
        end
        return x[23] ? (13'd4096 - g) : g;
    endfunction

    // captured item
    logic [1:0]          op_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [TAP_W-1:0]    tap_reg;
    logic signed [15:0]  data_reg;
    logic [ROW_W-1:0]    row;

    logic                bias_en_reg;
    logic [CLR_W-1:0]    clr_cnt_reg;
    logic [KCNT_W-1:0]   tap_cnt_reg;

    logic signed [15:0]  hist_q  [HIST_LEN];
    logic signed [15:0]  w_q     [NUM_TAPS];
    logic signed [15:0]  bias_q;
    logic signed [15:0]  ops     [NUM_TAPS];

    logic signed [39:0]  acc_reg;
    logic signed [39:0]  acc_base;
    logic signed [31:0]  prod;
    logic signed [23:0]  x_reg;
    logic [12:0]         sig_reg;
    logic signed [37:0]  sp_reg;
    logic signed [37:0]  y_full;

    logic                out_valid_reg;
    logic signed [15:0]  out_act_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [CH_W-1:0]     out_ch_reg;

    logic [15:0]         bmem [CHANNELS];

    assign row = {slot_reg, ch_reg};

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op;
            slot_reg <= in_slot;
            ch_reg   <= in_ch;
            tap_reg  <= in_tap;
            data_reg <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_en_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                bias_en_reg <= cfg_bit;
            end
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    assign sts.clr_last = (clr_cnt_reg == CLR_W'(ROWS - 1));

    // weight banks, one per tap, one row per channel
    for (genvar t = 0; t < NUM_TAPS; t++) begin : g_wbank
        logic [15:0] wmem [CHANNELS];
        always_ff @(posedge aclk) begin
            if (cmd.wr && op_reg == OP_WEIGHT && tap_reg == TAP_W'(t)) begin
                wmem[ch_reg] <= data_reg;
            end
            w_q[t] <= wmem[ch_reg];
        end
    end

    // history banks, one per stored tap, one row per slot and channel
    for (genvar h = 0; h < HIST_LEN; h++) begin : g_hbank
        logic [15:0] hmem [ROWS];
        logic        hwe;
        logic [ROW_W-1:0] haddr;
        logic [15:0] hdin;
        always_comb begin
            hwe   = 1'b0;
            haddr = row;
            hdin  = data_reg;
            if (cmd.clr) begin
                hwe   = 1'b1;
                haddr = ROW_W'(clr_cnt_reg);
                hdin  = '0;
            end else if (cmd.fin) begin
                hwe  = 1'b1;
                hdin = (h == HIST_LEN - 1) ? data_reg : hist_q[(h + 1) % HIST_LEN];
            end else if (cmd.wr && op_reg == OP_HIST && tap_reg == TAP_W'(h)) begin
                hwe = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (hwe) begin
                hmem[haddr] <= hdin;
            end
            hist_q[h] <= hmem[row];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            bmem[CH_W'(clr_cnt_reg)] <= '0;
        end else if (cmd.wr && op_reg == OP_BIAS) begin
            bmem[ch_reg] <= data_reg;
        end
        bias_q <= bmem[ch_reg];
    end

    // tap-serial dot product; bias joins with the first tap
    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            ops[i] = (i < HIST_LEN) ? hist_q[i % HIST_LEN] : data_reg;
        end
    end

    assign prod     = ops[tap_cnt_reg] * w_q[tap_cnt_reg];
    assign acc_base = bias_en_reg ? (40'(bias_q) <<< 12) : '0;
    assign sts.tap_last = (tap_cnt_reg == KCNT_W'(NUM_TAPS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            tap_cnt_reg <= '0;
        end else if (cmd.mac) begin
            tap_cnt_reg <= tap_cnt_reg + 1'b1;
            acc_reg     <= ((tap_cnt_reg == '0) ? acc_base : acc_reg) + 40'(prod);
        end
    end

    // round to Q.12, sigmoid, product, saturate
    always_ff @(posedge aclk) begin
        if (cmd.rnd) begin
            x_reg   <= 24'((acc_reg + 40'sd2048) >>> 12);
            sig_reg <= sigmoid_q12(24'((acc_reg + 40'sd2048) >>> 12));
        end
        if (cmd.mul) begin
            sp_reg <= x_reg * $signed({1'b0, sig_reg});
        end
    end

    assign y_full = (sp_reg + 38'sd2048) >>> 12;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.fin) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            out_slot_reg <= slot_reg;
            out_ch_reg   <= ch_reg;
            if (y_full > 38'sd32767) begin
                out_act_reg <= 16'sh7fff;
            end else if (y_full < -38'sd32768) begin
                out_act_reg <= 16'sh8000;
            end else begin
                out_act_reg <= 16'(y_full);
            end
        end
    end

    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_act      = out_act_reg;
    assign out_slot     = out_slot_reg;
    assign out_ch       = out_ch_reg;

endmodule

FILE: src/causal_conv_step_silu.sv
// ----------------------------------------------------------------------------
// causal_conv_step_silu
// Causal depthwise conv step with SiLU, Q4.12, one sample word at a time.
// ----------------------------------------------------------------------------
//  channel | ports                               | moves
//  --------+-------------------------------------+------------------------------
//  s_      | s_valid/s_ready, op, slot, ch, tap, | sample or store-write word
//          | data word                           |
//  m_      | m_valid/m_ready, activated, slot,ch | one result word per sample
//  cfg_    | cfg_valid/cfg_ready, cfg_data       | bias_enable register
//
//  Sample word steps: capture, read, 4 tap MAC steps through one 16x16
//  multiplier, round, SiLU multiply, writeback. Write word: capture, write.
//  Reset starts a clearing pass over all history and bias store rows;
//  s_ready stays low during it, cfg writes are always taken.
//  The result register holds one word; a stalled m_ side holds a finished
//  sample in its last cycle, while words ahead keep being accepted until then.
// ----------------------------------------------------------------------------
module causal_conv_step_silu
    import ccss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [SLOT_W-1:0]   s_batch_slot,
    input  logic [CH_W-1:0]     s_channel,
    input  logic [TAP_W-1:0]    s_tap_index,
    input  logic signed [15:0]  s_data_word,

    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [15:0]  m_activated,
    output logic [SLOT_W-1:0]   m_out_batch_slot,
    output logic [CH_W-1:0]     m_out_channel,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // register write is a single flop update, never stalls
    assign cfg_ready = 1'b1;

    ccss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_op    (op_t'(s_operation)),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccss_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_valid),
        .cfg_bit   (cfg_data),
        .in_op     (s_operation),
        .in_slot   (s_batch_slot),
        .in_ch     (s_channel),
        .in_tap    (s_tap_index),
        .in_data   (s_data_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_act   (m_activated),
        .out_slot  (m_out_batch_slot),
        .out_ch    (m_out_channel)
    );

endmodule

FILE: verif/causal_conv_step_silu_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// causal_conv_step_silu_tb
// Self-checking bench: weight, bias and history store writes plus samples on
// the s_ side, every result word on the m_ side checked in order against an
// in-bench model of the conv step and piecewise-linear SiLU.
// ----------------------------------------------------------------------------
module causal_conv_step_silu_tb;
    import ccss_pkg::*;

    localparam int IDLE_LIMIT = 20000;  // covers the clearing pass
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic signed [15:0] activated;
        logic [SLOT_W-1:0]  slot;
        logic [CH_W-1:0]    ch;
    } result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_operation = OP_SAMPLE;
    logic [SLOT_W-1:0]   s_batch_slot = '0;
    logic [CH_W-1:0]     s_channel = '0;
    logic [TAP_W-1:0]    s_tap_index = '0;
    logic signed [15:0]  s_data_word = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic signed [15:0]  m_activated;
    logic [SLOT_W-1:0]   m_out_batch_slot;
    logic [CH_W-1:0]     m_out_channel;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data = 1'b0;

    causal_conv_step_silu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_batch_slot(s_batch_slot), .s_channel(s_channel),
        .s_tap_index(s_tap_index), .s_data_word(s_data_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_activated(m_activated),
        .m_out_batch_slot(m_out_batch_slot), .m_out_channel(m_out_channel),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---- model state -------------------------------------------------------
    logic signed [15:0] hist_mem [ROWS][HIST_LEN];
    logic signed [15:0] weight_mem [CHANNELS][NUM_TAPS];
    bit                 weight_set [CHANNELS][NUM_TAPS];
    logic signed [15:0] bias_mem [CHANNELS];
    bit                 bias_on;

    result_t pending_results[$];
    int      live_channels[$];   // channels with every tap weight written
    int      err_count;
    int      idle_cycles;
    bit      gaps_on;            // random gaps on both sides
    bit      hold_req;
    int      hold_left;

    // Q1.12 sigmoid, piecewise linear in |x|
    function automatic longint sigmoid_q12(longint x);
        longint a, g;
        a = (x < 0) ? -x : x;
        if (a >= 20480) g = 4096;
        else if (a >= 9728) g = (a >>> 5) + 3456;
        else if (a >= 4096) g = (a >>> 3) + 2560;
        else g = (a >>> 2) + 2048;
        return (x < 0) ? 4096 - g : g;
    endfunction

    // apply one accepted word to the model, queue a result for samples
    task automatic predict_word(op_t op, int slot, int ch, int tap, logic signed [15:0] d);
        int      row;
        longint  acc, x, y;
        result_t r;
        bit      fresh;
        row = slot * CHANNELS + ch;
        case (op)
            OP_WEIGHT: begin
                fresh = !(weight_set[ch][0] && weight_set[ch][1] &&
                          weight_set[ch][2] && weight_set[ch][3]);
                weight_mem[ch][tap] = d;
                weight_set[ch][tap] = 1'b1;
                if (fresh && weight_set[ch][0] && weight_set[ch][1] &&
                    weight_set[ch][2] && weight_set[ch][3])
                    live_channels.push_back(ch);
            end
            OP_BIAS: bias_mem[ch] = d;
            OP_HIST: begin
                if (tap < HIST_LEN) hist_mem[row][tap] = d;   // tap 3 dropped
            end
            default: begin
                acc = bias_on ? longint'(bias_mem[ch]) * 4096 : 0;
                for (int i = 0; i < HIST_LEN; i++)
                    acc += longint'(hist_mem[row][i]) * longint'(weight_mem[ch][i]);
                acc += longint'(d) * longint'(weight_mem[ch][NUM_TAPS-1]);
                x = (acc + 2048) >>> 12;
                y = (x * sigmoid_q12(x) + 2048) >>> 12;
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                for (int i = 0; i + 1 < HIST_LEN; i++)
                    hist_mem[row][i] = hist_mem[row][i+1];
                hist_mem[row][HIST_LEN-1] = d;
                r.activated = y[15:0];
                r.slot = SLOT_W'(slot);
                r.ch = CH_W'(ch);
                pending_results.push_back(r);
            end
        endcase
    endtask

    function automatic int gap_len();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---- s_ side: one word per call, entered and left at a clock edge ------
    task automatic send_word(op_t op, int slot, int ch, int tap, logic signed [15:0] d);
        int gap;
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_batch_slot <= SLOT_W'(slot);
        s_channel    <= CH_W'(ch);
        s_tap_index  <= TAP_W'(tap);
        s_data_word  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(op, slot, ch, tap, d);
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // wait for all results, then let a trailing write word finish
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_bias_enable(bit v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        bias_on = v;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_data();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            2: return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
            default: return $signed(16'($urandom_range(0, 255))) - 16'sd128;
        endcase
    endfunction

    task automatic load_weights(int ch);
        for (int t = 0; t < NUM_TAPS; t++) send_word(OP_WEIGHT, 0, ch, t, rand_data());
    endtask

    // ---- m_ side: stall pattern, long hold on request ----------------------
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (!gaps_on) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 9) < 7) ||
                       (m_ready && $urandom_range(0, 3) != 0);
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        err_count++;
    endtask

    // result checker, compares against the oldest queued expectation
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, channel", m_out_channel, -1);
            end else begin
                e = pending_results.pop_front();
                if (m_activated !== e.activated)
                    report_mismatch("activated", m_activated, e.activated);
                if (m_out_batch_slot !== e.slot)
                    report_mismatch("batch_slot", m_out_batch_slot, e.slot);
                if (m_out_channel !== e.ch)
                    report_mismatch("channel", m_out_channel, e.ch);
            end
        end
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---- tests -------------------------------------------------------------
    task automatic test_directed();
        load_weights(0);
        send_word(OP_WEIGHT, 0, 1023, 0, 16'sh7FFF);
        send_word(OP_WEIGHT, 0, 1023, 1, -16'sd32768);
        send_word(OP_WEIGHT, 0, 1023, 2, 16'sd4096);
        send_word(OP_WEIGHT, 0, 1023, 3, 16'sh7FFF);
        send_word(OP_BIAS, 0, 0, 0, 16'sh7FFF);
        send_word(OP_HIST, 3, 1023, 0, -16'sd32768);
        send_word(OP_HIST, 3, 1023, 1, 16'sh7FFF);
        send_word(OP_HIST, 3, 1023, 2, 16'sd0);
        send_word(OP_HIST, 3, 1023, 3, 16'sh1234);   // beyond history, dropped
        send_word(OP_SAMPLE, 0, 0, 0, 16'sd0);
        send_word(OP_SAMPLE, 0, 0, 3, 16'sh7FFF);
        send_word(OP_SAMPLE, 0, 0, 0, -16'sd32768);
        send_word(OP_SAMPLE, 3, 1023, 0, 16'sh7FFF);
        send_word(OP_SAMPLE, 3, 1023, 0, -16'sd32768);
        send_word(OP_SAMPLE, 3, 1023, 0, 16'sd1);
    endtask

    task automatic test_bias_enable();
        write_bias_enable(1'b1);
        send_word(OP_SAMPLE, 0, 0, 0, 16'sd0);
        send_word(OP_BIAS, 0, 1023, 0, -16'sd32768);
        send_word(OP_SAMPLE, 1, 1023, 0, 16'sd100);
        write_bias_enable(1'b0);
        send_word(OP_SAMPLE, 0, 0, 0, 16'sd0);
        write_bias_enable(1'b1);
    endtask

    task automatic test_random(int n);
        int k, ch;
        load_weights(10'h155);
        load_weights(10'h2AA);
        k = 0;
        while (k < n) begin
            case ($urandom_range(0, 19))
                0: begin load_weights($urandom_range(0, CHANNELS-1)); k += 4; end
                1, 2: begin
                    send_word(OP_WEIGHT, $urandom_range(0, 3),
                              live_channels[$urandom_range(0, live_channels.size()-1)],
                              $urandom_range(0, 3), rand_data());
                    k++;
                end
                3, 4: begin
                    send_word(OP_BIAS, $urandom_range(0, 3), $urandom_range(0, CHANNELS-1),
                              $urandom_range(0, 3), rand_data());
                    k++;
                end
                5, 6: begin
                    send_word(OP_HIST, $urandom_range(0, 3), $urandom_range(0, CHANNELS-1),
                              $urandom_range(0, 3), rand_data());
                    k++;
                end
                default: begin
                    ch = live_channels[$urandom_range(0, live_channels.size()-1)];
                    send_word(OP_SAMPLE, $urandom_range(0, 3), ch,
                              $urandom_range(0, 3), rand_data());
                    k++;
                end
            endcase
            if (k % 200 < 4 && k > 4) write_bias_enable($urandom_range(0, 1));
        end
    endtask

    // receiver held off while the sender keeps offering samples
    task automatic test_backpressure();
        drain();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word(OP_SAMPLE, $urandom_range(0, 3),
                      live_channels[$urandom_range(0, live_channels.size()-1)],
                      0, rand_data());
    endtask

    initial begin
        err_count = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        bias_on = 1'b0;
        gaps_on = 1'b0;
        for (int r = 0; r < ROWS; r++)
            for (int i = 0; i < HIST_LEN; i++) hist_mem[r][i] = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            bias_mem[c] = '0;
            for (int t = 0; t < NUM_TAPS; t++) begin
                weight_mem[c][t] = '0;
                weight_set[c][t] = 1'b0;
            end
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();          // back to back, no stalls
        gaps_on = 1'b1;
        test_bias_enable();
        test_random(300);
        test_backpressure();
        gaps_on = 1'b0;
        test_random(100);         // stretch with no idling
        gaps_on = 1'b1;
        write_bias_enable(1'b0);
        test_random(200);

        drain();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
